// ===== src/vsgp_pkg.sv =====
package vsgp_pkg;

    localparam int VALUE_W = 64;
    localparam int HALF_W  = 32;
    localparam int GRP_W   = 6;
    localparam int DATA_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int STORE_W = 13;
    localparam int FILL_W  = 4;
    localparam int CNT_W   = 3;
    localparam int REM_W   = CNT_W + 1;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_RAW    = 2'd0,
        ACT_EXT32  = 2'd1,
        ACT_PAIR64 = 2'd2,
        ACT_FINISH = 2'd3
    } t_action;

    // One classified request waiting for the back end.
    typedef struct packed {
        t_action                action;
        logic [VALUE_W-1:0]     value;
        logic [CNT_W-1:0]       n_lo;   // groups of the low half (or 1)
        logic [CNT_W-1:0]       n_hi;   // groups of the high half, 0 unless pair
    } t_item;

    typedef struct packed {
        logic              busy;
        logic [FILL_W-1:0] fill;
    } t_back_stat;

endpackage

// ===== src/vsgp_front.sv =====
module vsgp_front (
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_action,
    input  logic [vsgp_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_push,
    input  logic                           i_push_ready,
    output vsgp_pkg::t_item                o_item
);

    // Number of 5-bit groups a 32-bit value needs (at least one).
    function automatic logic [vsgp_pkg::CNT_W-1:0] count_groups(
        input logic [vsgp_pkg::HALF_W-1:0] v
    );
        logic [5:0] above;
        begin
            above = {|v[31:30], |v[31:25], |v[31:20], |v[31:15], |v[31:10], |v[31:5]};
            count_groups = vsgp_pkg::CNT_W'($countones(above)) + vsgp_pkg::CNT_W'(1);
        end
    endfunction

    vsgp_pkg::t_action w_action;

    assign w_action = vsgp_pkg::t_action'(i_action);
    assign o_ready  = i_push_ready;
    assign o_push   = i_valid;

    always_comb begin
        o_item.action = w_action;
        o_item.value  = i_value;
        o_item.n_lo   = vsgp_pkg::CNT_W'(1);
        o_item.n_hi   = '0;
        unique case (w_action)
            vsgp_pkg::ACT_EXT32: begin
                o_item.n_lo = count_groups(i_value[vsgp_pkg::HALF_W-1:0]);
            end
            vsgp_pkg::ACT_PAIR64: begin
                o_item.n_lo = count_groups(i_value[vsgp_pkg::HALF_W-1:0]);
                o_item.n_hi = count_groups(i_value[vsgp_pkg::VALUE_W-1:vsgp_pkg::HALF_W]);
            end
            default: begin
                o_item.n_lo = vsgp_pkg::CNT_W'(1);
            end
        endcase
    end

endmodule

// ===== src/vsgp_queue.sv =====
module vsgp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  vsgp_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_pop,
    output vsgp_pkg::t_item  o_item
);

    vsgp_pkg::t_item                r_mem [vsgp_pkg::Q_DEPTH];
    logic [vsgp_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [vsgp_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [vsgp_pkg::Q_CNT_W-1:0]   r_count;
    logic                           w_wr;
    logic                           w_rd;

    assign o_push_ready = (r_count != vsgp_pkg::Q_CNT_W'(vsgp_pkg::Q_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;

    function automatic logic [vsgp_pkg::Q_PTR_W-1:0] next_ptr(
        input logic [vsgp_pkg::Q_PTR_W-1:0] p
    );
        begin
            if (p == vsgp_pkg::Q_PTR_W'(vsgp_pkg::Q_DEPTH - 1)) begin
                next_ptr = '0;
            end else begin
                next_ptr = p + vsgp_pkg::Q_PTR_W'(1);
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + vsgp_pkg::Q_CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - vsgp_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/vsgp_back.sv =====
module vsgp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  vsgp_pkg::t_item               i_q_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vsgp_pkg::BYTE_W-1:0]   o_byte,
    output logic                          o_last,
    output vsgp_pkg::t_back_stat          o_stat
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                             r_state,      n_state;
    vsgp_pkg::t_action                  r_act,        n_act;
    logic [vsgp_pkg::HALF_W-1:0]        r_val,        n_val;
    logic [vsgp_pkg::HALF_W-1:0]        r_hi,         n_hi;
    logic [vsgp_pkg::CNT_W-1:0]         r_left_half,  n_left_half;
    logic [vsgp_pkg::CNT_W-1:0]         r_left_hi,    n_left_hi;
    logic [vsgp_pkg::STORE_W-1:0]       r_store,      n_store;
    logic [vsgp_pkg::FILL_W-1:0]        r_fill,       n_fill;
    logic                               r_out_valid,  n_out_valid;
    logic [vsgp_pkg::BYTE_W-1:0]        r_out_byte,   n_out_byte;
    logic                               r_out_last,   n_out_last;

    logic                               w_out_ok;
    logic [vsgp_pkg::GRP_W-1:0]         w_group;
    logic [vsgp_pkg::STORE_W-1:0]       w_sum;
    logic [vsgp_pkg::FILL_W-1:0]        w_fill6;
    logic [vsgp_pkg::REM_W-1:0]         w_rem;

    assign w_out_ok = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_last   = r_out_last;
    assign o_stat   = '{busy: (r_state == ST_RUN), fill: r_fill};

    // Group for the current step: raw takes six bits, a varint takes five
    // plus a continuation flag while more groups of the same half follow.
    always_comb begin
        if (r_act == vsgp_pkg::ACT_RAW) begin
            w_group = r_val[vsgp_pkg::GRP_W-1:0];
        end else begin
            w_group = {(r_left_half != vsgp_pkg::CNT_W'(1)), r_val[vsgp_pkg::DATA_W-1:0]};
        end
        w_sum   = r_store | (vsgp_pkg::STORE_W'(w_group) << r_fill);
        w_fill6 = r_fill + vsgp_pkg::FILL_W'(vsgp_pkg::GRP_W);
        w_rem   = vsgp_pkg::REM_W'(r_left_half) - vsgp_pkg::REM_W'(1)
                + vsgp_pkg::REM_W'(r_left_hi);
    end

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_val       = r_val;
        n_hi        = r_hi;
        n_left_half = r_left_half;
        n_left_hi   = r_left_hi;
        n_store     = r_store;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop       = 1'b1;
                    n_act       = i_q_item.action;
                    n_val       = i_q_item.value[vsgp_pkg::HALF_W-1:0];
                    n_hi        = i_q_item.value[vsgp_pkg::VALUE_W-1:vsgp_pkg::HALF_W];
                    n_left_half = i_q_item.n_lo;
                    n_left_hi   = i_q_item.n_hi;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_out_ok) begin
                    if (r_act == vsgp_pkg::ACT_FINISH) begin
                        if (r_fill != '0) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = r_store[vsgp_pkg::BYTE_W-1:0];
                            n_out_last  = 1'b1;
                        end
                        n_store = '0;
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        if (w_fill6 >= vsgp_pkg::FILL_W'(vsgp_pkg::BYTE_W)) begin
                            n_store     = w_sum >> vsgp_pkg::BYTE_W;
                            n_fill      = w_fill6 - vsgp_pkg::FILL_W'(vsgp_pkg::BYTE_W);
                            n_out_valid = 1'b1;
                            n_out_byte  = w_sum[vsgp_pkg::BYTE_W-1:0];
                            // last unless a later group of this request still
                            // completes a byte
                            n_out_last  = !((w_rem >= vsgp_pkg::REM_W'(2)) ||
                                            ((w_rem == vsgp_pkg::REM_W'(1)) &&
                                             (n_fill >= vsgp_pkg::FILL_W'(2))));
                        end else begin
                            n_store = w_sum;
                            n_fill  = w_fill6;
                        end
                        if (r_left_half == vsgp_pkg::CNT_W'(1)) begin
                            if (r_left_hi == '0) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_val       = r_hi;
                                n_left_half = r_left_hi;
                                n_left_hi   = '0;
                            end
                        end else begin
                            n_val       = r_val >> vsgp_pkg::DATA_W;
                            n_left_half = r_left_half - vsgp_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_store     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_store     <= n_store;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_act       <= n_act;
        r_val       <= n_val;
        r_hi        <= n_hi;
        r_left_half <= n_left_half;
        r_left_hi   <= n_left_hi;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
    end

endmodule

// ===== src/varint_six_bit_group_packer.sv =====
// Channel  | Dir | Signals                                  | Contents
// ---------+-----+------------------------------------------+------------------------------
// command  | in  | s_axis_tvalid/tready/tdata[63:0]/tuser   | tdata: value; tuser: action
// bytes    | out | m_axis_tvalid/tready/tdata[7:0]/tlast    | tdata: out_byte; tlast: last
//
// A request is loaded from the queue, then packed one 6-bit group per cycle
// unless the byte side stalls; the single group shifter takes no new request
// until the last is done, and finish flushes the buffer. One byte leaves per cycle at most.
// Reset (synchronous, active low) empties the queue and clears the bit buffer.
// A stall on the byte side holds the back end; the two-entry queue keeps
// accepting commands until it fills.
module varint_six_bit_group_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);

    logic                  w_push;
    logic                  w_push_ready;
    vsgp_pkg::t_item       w_front_item;
    logic                  w_q_valid;
    logic                  w_pop;
    vsgp_pkg::t_item       w_q_item;
    vsgp_pkg::t_back_stat  w_stat;

    // Classify: count varint groups per half before queueing.
    vsgp_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_value      (s_axis_tdata),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_item       (w_front_item)
    );

    // Decouple command intake from byte emission.
    vsgp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_item       (w_front_item),
        .o_valid      (w_q_valid),
        .i_pop        (w_pop),
        .o_item       (w_q_item)
    );

    // Pack groups into the bit buffer and drive the output register.
    vsgp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_stat    (w_stat)
    );

    // Between groups the buffer holds an even count of bits below one byte.
    a_fill_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.fill[0] == 1'b0) && (w_stat.fill <= 4'd6))
        else $error("bit fill out of range");

    // Pop only from a non-empty queue and only while the back end is free.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_valid && !w_stat.busy))
        else $error("queue pop while busy or empty");

    // A popped request always starts the back end.
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> w_stat.busy)
        else $error("popped request not started");

endmodule
